// ===== hdl/offset_high_cv_access_sequencer_unit_defines.svh =====
// assertion macros shared by the checker
`ifndef OFFSET_HIGH_CV_ACCESS_SEQUENCER_UNIT_DEFINES_SVH
`define OFFSET_HIGH_CV_ACCESS_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define OHCV_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ohcv same-cycle check failed");

// next-cycle implication, quiet during reset
`define OHCV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ohcv next-cycle check failed");

// next-cycle implication that also watches reset itself
`define OHCV_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ohcv reset check failed");

`endif

// ===== hdl/ohcv_pkg.sv =====
package ohcv_pkg;

  localparam int CV_BITS  = 16;
  localparam int CNT_W    = $clog2(CV_BITS + 1);
  localparam int SPLIT_W  = 10;
  localparam int PROD_W   = CV_BITS + 8;
  localparam int SUM_W    = PROD_W + 1;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_REPLY = 2'd2;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_BUSY  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECT_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_CV      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_FACTOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_MODULUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_OFFSET  = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] cv_number;
    logic [7:0]  write_data;
    logic [3:0]  client_tag;
    logic        direct_capable;
    logic [7:0]  reply_data;
    logic [7:0]  reply_code;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] target_cv;
    logic [7:0]  data_out;
    logic [7:0]  status_out;
  } out_word_t;

  typedef struct packed {
    logic [15:0]        direct_top;
    logic [9:0]         index_cv;
    logic [7:0]         high_factor;
    logic [SPLIT_W-1:0] split_modulus;
    logic [7:0]         index_offset;
  } cfg_regs_t;

endpackage

// ===== hdl/ohcv_cfg_regs.sv =====
module ohcv_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ohcv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_wdata,
  output ohcv_pkg::cfg_regs_t           regs
);
  import ohcv_pkg::*;

  cfg_regs_t regs_r, regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_DIRECT_TOP:    regs_nxt.direct_top    = cfg_wdata;
        REG_INDEX_CV:      regs_nxt.index_cv      = cfg_wdata[9:0];
        REG_HIGH_FACTOR:   regs_nxt.high_factor   = cfg_wdata[7:0];
        REG_SPLIT_MODULUS: regs_nxt.split_modulus = cfg_wdata[SPLIT_W-1:0];
        REG_INDEX_OFFSET:  regs_nxt.index_offset  = cfg_wdata[7:0];
        default:           regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.direct_top    <= 16'd255;
      regs_r.index_cv      <= 10'd7;
      regs_r.high_factor   <= 8'd10;
      regs_r.split_modulus <= SPLIT_W'(100);
      regs_r.index_offset  <= 8'd200;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

// ===== hdl/ohcv_div.sv =====
module ohcv_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ohcv_pkg::CV_BITS-1:0] dividend,
  input  logic [ohcv_pkg::SPLIT_W-1:0] divisor,
  output logic                        done,
  output logic [ohcv_pkg::CV_BITS-1:0] quot,
  output logic [ohcv_pkg::CV_BITS-1:0] rem
);
  import ohcv_pkg::*;

  logic [CV_BITS-1:0] q_r, q_nxt;
  logic [CV_BITS-1:0] r_r, r_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CV_BITS:0]   shifted;
  logic [CV_BITS:0]   div_ext;
  logic               fits;

  // one quotient bit per cycle, restoring; a zero divisor gives all ones and the dividend back
  always_comb begin
    shifted  = {r_r, q_r[CV_BITS-1]};
    div_ext  = (CV_BITS+1)'(divisor);
    fits     = (shifted >= div_ext);
    q_nxt    = q_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      cnt_nxt  = CNT_W'(CV_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      r_nxt   = fits ? CV_BITS'(shifted - div_ext) : CV_BITS'(shifted);
      q_nxt   = {q_r[CV_BITS-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

// ===== hdl/offset_high_cv_access_sequencer_unit.sv =====
// Sequences client CV reads and writes onto a programmer, one input word at a time.
// A client request at or below direct_top, or marked direct_capable, gets one direct
// operation: the decode state fills the result register, the emit state moves it into
// the output register and the next word can be taken after that. A request above it
// needs cv / split_modulus, and a programmer reply that issues the low access needs
// cv mod split_modulus; both run on one shared bit-serial divider that is started,
// works through the CV_BITS (16) quotient bits and signals done. The index word then
// adds a multiply and a saturating add. in_stall is high from acceptance until the
// result word is in the output register, longer only while a full output register is
// stalled; a word that raises no result keeps it high only in the decode state. A pending
// output word does not hold off the next input word.
module offset_high_cv_access_sequencer_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ohcv_pkg::in_word_t             in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ohcv_pkg::out_word_t            out_word,
  input  logic                           cfg_we,
  input  logic [ohcv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_wdata
);
  import ohcv_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DEC  = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_SAT  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  typedef enum logic [4:0] {
    PH_IDLE        = 5'b00001,
    PH_PROGRAMMING = 5'b00010,
    PH_FINISHREAD  = 5'b00100,
    PH_FINISHWRITE = 5'b01000,
    PH_RESET       = 5'b10000
  } phase_t;

  cfg_regs_t cfg;

  state_t             state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  logic               owner_valid_r, owner_valid_nxt;
  logic [3:0]         owner_tag_r, owner_tag_nxt;
  logic [CV_BITS-1:0] saved_cv_r, saved_cv_nxt;
  logic [7:0]         saved_data_r, saved_data_nxt;
  logic               indirect_read_r, indirect_read_nxt;
  logic               for_index_r, for_index_nxt;
  in_word_t           item_r;
  out_word_t          res_r, res_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r;

  logic               in_take;
  logic               out_load;
  logic               div_start;
  logic [CV_BITS-1:0] div_dividend;
  logic               div_done;
  logic [CV_BITS-1:0] div_quot;
  logic [CV_BITS-1:0] div_rem;
  logic [CV_BITS-1:0] cv_in;
  logic               is_write;
  logic [SUM_W-1:0]   idx_sum;

  ohcv_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (cfg)
  );

  ohcv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cfg.split_modulus),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign cv_in    = CV_BITS'(item_r.cv_number);
  assign is_write = (item_r.command == CMD_WRITE);
  assign idx_sum  = SUM_W'(prod_r) + SUM_W'(cfg.index_offset);

  always_comb begin
    state_nxt         = state_r;
    phase_nxt         = phase_r;
    owner_valid_nxt   = owner_valid_r;
    owner_tag_nxt     = owner_tag_r;
    saved_cv_nxt      = saved_cv_r;
    saved_data_nxt    = saved_data_r;
    indirect_read_nxt = indirect_read_r;
    for_index_nxt     = for_index_r;
    res_nxt           = res_r;
    prod_nxt          = prod_r;
    div_start         = 1'b0;
    div_dividend      = saved_cv_r;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        res_nxt   = '0;
        state_nxt = S_IDLE;
        case (item_r.command)
          CMD_READ, CMD_WRITE: begin
            if (owner_valid_r && (owner_tag_r != item_r.client_tag)) begin
              res_nxt.result_kind = KIND_BUSY;
              state_nxt           = S_EMIT;
            end else begin
              owner_valid_nxt = 1'b1;
              owner_tag_nxt   = item_r.client_tag;
              saved_cv_nxt    = cv_in;
              saved_data_nxt  = is_write ? item_r.write_data : 8'd0;
              if (item_r.direct_capable || (16'(cv_in) <= cfg.direct_top)) begin
                phase_nxt           = PH_PROGRAMMING;
                indirect_read_nxt   = 1'b0;
                res_nxt.result_kind = is_write ? KIND_WRITE : KIND_READ;
                res_nxt.target_cv   = 16'(cv_in);
                res_nxt.data_out    = saved_data_nxt;
                state_nxt           = S_EMIT;
              end else begin
                phase_nxt         = is_write ? PH_FINISHWRITE : PH_FINISHREAD;
                indirect_read_nxt = !is_write;
                div_start         = 1'b1;
                div_dividend      = cv_in;
                for_index_nxt     = 1'b1;
                state_nxt         = S_DIV;
              end
            end
          end

          CMD_REPLY: begin
            if (item_r.reply_code != 8'd0) begin
              phase_nxt       = PH_IDLE;
              owner_valid_nxt = 1'b0;
              if (owner_valid_r) begin
                res_nxt.result_kind = KIND_DONE;
                res_nxt.data_out    = item_r.reply_data;
                res_nxt.status_out  = item_r.reply_code;
                state_nxt           = S_EMIT;
              end
            end else if (!owner_valid_r) begin
              phase_nxt       = PH_IDLE;
              owner_valid_nxt = 1'b0;
            end else begin
              case (phase_r)
                PH_FINISHREAD, PH_FINISHWRITE: begin
                  phase_nxt     = PH_RESET;
                  div_start     = 1'b1;
                  for_index_nxt = 1'b0;
                  if (phase_r == PH_FINISHWRITE) begin
                    res_nxt.result_kind = KIND_WRITE;
                    res_nxt.data_out    = saved_data_r;
                  end else begin
                    res_nxt.result_kind = KIND_READ;
                  end
                  state_nxt = S_DIV;
                end
                PH_RESET: begin
                  if (indirect_read_r) begin
                    saved_data_nxt = item_r.reply_data;
                  end
                  phase_nxt           = PH_PROGRAMMING;
                  res_nxt.result_kind = KIND_WRITE;
                  res_nxt.target_cv   = 16'(cfg.index_cv);
                  state_nxt           = S_EMIT;
                end
                PH_PROGRAMMING: begin
                  phase_nxt           = PH_IDLE;
                  owner_valid_nxt     = 1'b0;
                  res_nxt.result_kind = KIND_DONE;
                  res_nxt.data_out    = indirect_read_r ? saved_data_r : item_r.reply_data;
                  state_nxt           = S_EMIT;
                end
                default: begin
                  phase_nxt       = PH_IDLE;
                  owner_valid_nxt = 1'b0;
                end
              endcase
            end
          end

          default: state_nxt = S_IDLE;
        endcase
      end

      S_DIV: begin
        if (div_done) begin
          if (for_index_r) begin
            state_nxt = S_MUL;
          end else begin
            res_nxt.target_cv = 16'(div_rem);
            state_nxt         = S_EMIT;
          end
        end
      end

      S_MUL: begin
        prod_nxt  = PROD_W'(div_quot) * PROD_W'(cfg.high_factor);
        state_nxt = S_SAT;
      end

      S_SAT: begin
        res_nxt.result_kind = KIND_WRITE;
        res_nxt.target_cv   = 16'(cfg.index_cv);
        res_nxt.data_out    = (idx_sum > SUM_W'(255)) ? 8'hFF : idx_sum[7:0];
        res_nxt.status_out  = 8'd0;
        state_nxt           = S_EMIT;
      end

      S_EMIT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      phase_r         <= PH_IDLE;
      owner_valid_r   <= 1'b0;
      owner_tag_r     <= '0;
      saved_cv_r      <= '0;
      saved_data_r    <= '0;
      indirect_read_r <= 1'b0;
      for_index_r     <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      phase_r         <= phase_nxt;
      owner_valid_r   <= owner_valid_nxt;
      owner_tag_r     <= owner_tag_nxt;
      saved_cv_r      <= saved_cv_nxt;
      saved_data_r    <= saved_data_nxt;
      indirect_read_r <= indirect_read_nxt;
      for_index_r     <= for_index_nxt;
      out_valid_r     <= out_valid_nxt;
    end
    if (in_take) begin
      item_r <= in_word;
    end
    res_r  <= res_nxt;
    prod_r <= prod_nxt;
    if (out_load) begin
      out_word_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== hdl/ohcv_checker.sv =====
`include "offset_high_cv_access_sequencer_unit_defines.svh"

module ohcv_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ohcv_pkg::out_word_t out_word
);
  import ohcv_pkg::*;

  // a held result word stays put
  `OHCV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

  // an accepted word keeps the input closed in the following cycle
  `OHCV_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)

  // only a completion word carries a status
  `OHCV_ASSERT_SAME(a_status_done_only, out_valid && (out_word.result_kind != KIND_DONE),
    out_word.status_out == 8'd0)

  // reset empties the result register
  `OHCV_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid)

endmodule

bind offset_high_cv_access_sequencer_unit ohcv_checker u_ohcv_checker (.*);

// ===== verif/tb_offset_high_cv_access_sequencer_unit.sv =====
module tb_offset_high_cv_access_sequencer_unit;
  import ohcv_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_WORDS = 88;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_PROGRAMMING,
    SEQ_FINISH_READ,
    SEQ_FINISH_WRITE,
    SEQ_RESET
  } seq_state_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  in_word_t word_feed[$];
  out_word_t awaited_results[$];

  // shadow of the sequencer
  cfg_regs_t shadow_regs;
  seq_state_e seq_state;
  bit owner_valid;
  logic [3:0] owner_tag;
  logic [15:0] saved_cv;
  logic [7:0] saved_data;
  bit indirect_rd;

  bit in_acc = 1'b0;
  bit out_acc = 1'b0;
  bit in_gaps_on = 1'b1;
  bit out_stalls_on = 1'b1;
  int gap_left = 0;
  int out_hold = 0;
  int cycle_count = 0;
  int fault_count = 0;
  int queued_words = 0;
  int accepted_words = 0;
  int result_words = 0;
  int busy_seen = 0;
  int done_seen = 0;
  int settings_count = 0;

  offset_high_cv_access_sequencer_unit i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial forever #1 clk = ~clk;

  task automatic advance_sequence(input in_word_t w, output bit produced,
                                  output out_word_t r);
    logic [15:0] quot;
    longint unsigned idx;
    bit is_wr;
    produced = 1'b0;
    r = '0;
    is_wr = (w.command == CMD_WRITE);
    if (w.command == CMD_READ || w.command == CMD_WRITE) begin
      produced = 1'b1;
      if (owner_valid && owner_tag != w.client_tag) begin
        r.result_kind = KIND_BUSY;
      end else begin
        owner_valid = 1'b1;
        owner_tag = w.client_tag;
        saved_cv = w.cv_number;
        saved_data = is_wr ? w.write_data : 8'd0;
        if (w.direct_capable || w.cv_number <= shadow_regs.direct_top) begin
          seq_state = SEQ_PROGRAMMING;
          indirect_rd = 1'b0;
          r.result_kind = is_wr ? KIND_WRITE : KIND_READ;
          r.target_cv = w.cv_number;
          r.data_out = saved_data;
        end else begin
          // zero modulus gives an all-ones quotient
          quot = (shadow_regs.split_modulus == 0) ? 16'hFFFF
                 : w.cv_number / shadow_regs.split_modulus;
          idx = 64'(quot);
          idx = idx * shadow_regs.high_factor + shadow_regs.index_offset;
          seq_state = is_wr ? SEQ_FINISH_WRITE : SEQ_FINISH_READ;
          indirect_rd = !is_wr;
          r.result_kind = KIND_WRITE;
          r.target_cv = 16'(shadow_regs.index_cv);
          r.data_out = (idx > 255) ? 8'hFF : idx[7:0];
        end
      end
    end else if (w.command == CMD_REPLY) begin
      if (w.reply_code != 0) begin
        if (owner_valid) begin
          produced = 1'b1;
          r.result_kind = KIND_DONE;
          r.data_out = w.reply_data;
          r.status_out = w.reply_code;
        end
        seq_state = SEQ_IDLE;
        owner_valid = 1'b0;
      end else if (!owner_valid) begin
        seq_state = SEQ_IDLE;
      end else begin
        produced = 1'b1;
        case (seq_state)
          SEQ_FINISH_READ, SEQ_FINISH_WRITE: begin
            r.result_kind = (seq_state == SEQ_FINISH_WRITE) ? KIND_WRITE : KIND_READ;
            r.target_cv = (shadow_regs.split_modulus == 0) ? saved_cv
                          : saved_cv % shadow_regs.split_modulus;
            r.data_out = (seq_state == SEQ_FINISH_WRITE) ? saved_data : 8'd0;
            seq_state = SEQ_RESET;
          end
          SEQ_RESET: begin
            // keep the value read from the low cv
            if (indirect_rd) saved_data = w.reply_data;
            seq_state = SEQ_PROGRAMMING;
            r.result_kind = KIND_WRITE;
            r.target_cv = 16'(shadow_regs.index_cv);
          end
          SEQ_PROGRAMMING: begin
            r.result_kind = KIND_DONE;
            r.data_out = indirect_rd ? saved_data : w.reply_data;
            seq_state = SEQ_IDLE;
            owner_valid = 1'b0;
          end
          default: begin
            produced = 1'b0;
            seq_state = SEQ_IDLE;
            owner_valid = 1'b0;
          end
        endcase
      end
    end
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h got %0h", $time, what, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    out_word_t want;
    out_word_t predicted;
    bit produced;
    if (!rst_n) begin
      in_acc <= 1'b0;
      out_acc <= 1'b0;
    end else begin
      in_acc <= in_valid && !in_stall;
      out_acc <= out_valid && !out_stall;
      if (out_valid && !out_stall) begin
        result_words++;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none got %h", $time, out_word);
          fault_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("result_kind", 16'(want.result_kind), 16'(out_word.result_kind));
          check_field("target_cv", want.target_cv, out_word.target_cv);
          check_field("data_out", 16'(want.data_out), 16'(out_word.data_out));
          check_field("status_out", 16'(want.status_out), 16'(out_word.status_out));
          if (want.result_kind == KIND_BUSY) busy_seen++;
          if (want.result_kind == KIND_DONE) done_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        accepted_words++;
        advance_sequence(in_word, produced, predicted);
        if (produced) awaited_results.push_back(predicted);
      end
    end
  end

  always @(negedge clk) begin : feeder
    if (rst_n) begin
      if (!in_valid || in_acc) begin
        if (gap_left == 0 && word_feed.size() > 0) begin
          in_word <= word_feed.pop_front();
          in_valid <= 1'b1;
          gap_left <= in_gaps_on ? int'($urandom_range(0, 11)) : 0;
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end
      end
    end
  end

  always @(negedge clk) begin : result_sink
    int hold;
    if (rst_n) begin
      hold = out_acc ? (out_stalls_on ? int'($urandom_range(0, 11)) : 0) : out_hold;
      out_stall <= (hold > 0);
      if (out_valid && hold > 0) out_hold <= hold - 1;
      else out_hold <= hold;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run did not finish in time", $time);
    $display("status: fail");
    $finish;
  end

  task automatic push_word(input logic [1:0] cmd, input logic [15:0] cv,
                           input logic [7:0] wd, input logic [3:0] tag, input logic dc,
                           input logic [7:0] rd, input logic [7:0] rc);
    in_word_t w;
    w.command = cmd;
    w.cv_number = cv;
    w.write_data = wd;
    w.client_tag = tag;
    w.direct_capable = dc;
    w.reply_data = rd;
    w.reply_code = rc;
    word_feed.push_back(w);
    queued_words++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_DIRECT_TOP: shadow_regs.direct_top = val;
      REG_INDEX_CV: shadow_regs.index_cv = val[9:0];
      REG_HIGH_FACTOR: shadow_regs.high_factor = val[7:0];
      REG_SPLIT_MODULUS: shadow_regs.split_modulus = val[9:0];
      REG_INDEX_OFFSET: shadow_regs.index_offset = val[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] top, input logic [9:0] icv,
                                input logic [7:0] fac, input logic [9:0] modv,
                                input logic [7:0] off);
    write_reg(REG_DIRECT_TOP, top);
    write_reg(REG_INDEX_CV, 16'(icv));
    write_reg(REG_HIGH_FACTOR, 16'(fac));
    write_reg(REG_SPLIT_MODULUS, 16'(modv));
    write_reg(REG_INDEX_OFFSET, 16'(off));
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  task automatic wait_idle();
    while (accepted_words != queued_words || awaited_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one client access with its replies, now and then interrupted
  task automatic queue_access();
    logic [15:0] cv;
    logic [3:0] tag;
    logic [1:0] cmd;
    logic [7:0] rc;
    bit dc;
    int steps;
    cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
    tag = 4'($urandom_range(0, 15));
    dc = ($urandom_range(0, 9) == 0);
    case ($urandom_range(0, 5))
      0: cv = 16'($urandom_range(0, shadow_regs.direct_top));
      1: cv = shadow_regs.direct_top + 16'd1;
      2: cv = 16'hFFFF;
      default: cv = 16'($urandom_range(0, 65535));
    endcase
    steps = (dc || cv <= shadow_regs.direct_top) ? 1 : 3;
    if ($urandom_range(0, 14) == 0) begin
      // same client starts again part way through
      push_word(cmd, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), tag,
                1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
      push_word(CMD_REPLY, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                8'($urandom_range(0, 255)), 8'd0);
    end
    push_word(cmd, cv, 8'($urandom_range(0, 255)), tag, dc, 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
    for (int s = 0; s < steps; s++) begin
      if ($urandom_range(0, 11) == 0)
        push_word($urandom_range(0, 1) ? CMD_WRITE : CMD_READ,
                  16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                  tag ^ 4'($urandom_range(1, 15)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      rc = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
      push_word(CMD_REPLY, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                8'($urandom_range(0, 255)), rc);
      if (rc != 0) break;
    end
  endtask

  task automatic queue_noise();
    push_word($urandom_range(0, 1) ? CMD_UNUSED : CMD_REPLY, 16'($urandom_range(0, 65535)),
              8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
              1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    int target;
    shadow_regs = '{direct_top: 16'd255, index_cv: 10'd7, high_factor: 8'd10,
                    split_modulus: 10'd100, index_offset: 8'd200};
    seq_state = SEQ_IDLE;
    owner_valid = 1'b0;
    owner_tag = '0;
    saved_cv = '0;
    saved_data = '0;
    indirect_rd = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // direct read and write at the ends of the direct range
    push_word(CMD_READ, 16'd0, 8'd0, 4'd1, 1'b0, 8'd0, 8'd0);
    push_word(CMD_REPLY, 16'd0, 8'd0, 4'd1, 1'b0, 8'h5A, 8'd0);
    push_word(CMD_WRITE, 16'd255, 8'hFF, 4'd0, 1'b0, 8'd0, 8'd0);
    push_word(CMD_REPLY, 16'd0, 8'd0, 4'd0, 1'b0, 8'hC3, 8'd0);
    // indirect read keeps the low cv value
    push_word(CMD_READ, 16'hFFFF, 8'd0, 4'd15, 1'b0, 8'd0, 8'd0);
    push_word(CMD_REPLY, 16'd0, 8'd0, 4'd15, 1'b0, 8'h00, 8'd0);
    push_word(CMD_REPLY, 16'd0, 8'd0, 4'd15, 1'b0, 8'hA5, 8'd0);
    push_word(CMD_REPLY, 16'd0, 8'd0, 4'd15, 1'b0, 8'h11, 8'd0);
    // indirect write reports the last reply data
    push_word(CMD_WRITE, 16'd256, 8'h80, 4'd2, 1'b0, 8'd0, 8'd0);
    push_word(CMD_REPLY, 16'd0, 8'd0, 4'd2, 1'b0, 8'h01, 8'd0);
    push_word(CMD_REPLY, 16'd0, 8'd0, 4'd2, 1'b0, 8'h02, 8'd0);
    push_word(CMD_REPLY, 16'd0, 8'd0, 4'd2, 1'b0, 8'h33, 8'd0);
    // busy rejection, owner restart, then an error aborts
    push_word(CMD_READ, 16'd1000, 8'd0, 4'd3, 1'b0, 8'd0, 8'd0);
    push_word(CMD_READ, 16'd5, 8'd0, 4'd4, 1'b0, 8'd0, 8'd0);
    push_word(CMD_WRITE, 16'd300, 8'h7E, 4'd3, 1'b0, 8'd0, 8'd0);
    push_word(CMD_REPLY, 16'd0, 8'd0, 4'd3, 1'b0, 8'h44, 8'hFF);
    // stray replies and the unused command
    push_word(CMD_REPLY, 16'd0, 8'd0, 4'd0, 1'b0, 8'h12, 8'h80);
    push_word(CMD_REPLY, 16'd0, 8'd0, 4'd0, 1'b0, 8'h34, 8'd0);
    push_word(CMD_UNUSED, 16'hFFFF, 8'hFF, 4'hF, 1'b1, 8'hFF, 8'hFF);
    // programmer reaches a high cv directly
    push_word(CMD_READ, 16'hFFFF, 8'd0, 4'd9, 1'b1, 8'd0, 8'd0);
    push_word(CMD_REPLY, 16'd0, 8'd0, 4'd9, 1'b0, 8'h66, 8'd1);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_settings(16'd0, 10'd1023, 8'd255, 10'd1, 8'd255);
        1: apply_settings(16'hFFFF, 10'd0, 8'd0, 10'd1023, 8'd0);
        2: apply_settings(16'd100, 10'd512, 8'd0, 10'd0, 8'd77);
        3: apply_settings(16'd0, 10'd3, 8'd1, 10'd0, 8'd0);
        default: apply_settings(($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                : 16'($urandom_range(0, 1500)),
                                10'($urandom_range(0, 1023)),
                                8'($urandom_range(0, 255)), 10'($urandom_range(1, 1023)),
                                8'($urandom_range(0, 255)));
      endcase
      in_gaps_on = (p % 2 == 0);
      out_stalls_on = (p % 3 != 1);
      target = queued_words + PHASE_WORDS;
      while (queued_words < target) begin
        if ($urandom_range(0, 7) == 0) queue_noise();
        else queue_access();
      end
      wait_idle();
    end

    $display("covered %0d input words under %0d register settings besides reset values",
             accepted_words, settings_count);
    $display("checked %0d result words: %0d completions, %0d busy rejections",
             result_words, done_seen, busy_seen);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
